@@ design/utf8_scalar_decoder_validator_assert.svh @@
// assertion macros used by the utf8 decoder output stage
`ifndef UTF8_SCALAR_DECODER_VALIDATOR_ASSERT_SVH
`define UTF8_SCALAR_DECODER_VALIDATOR_ASSERT_SVH

// condition must hold at every rising clock edge out of reset
`define UTF8_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("utf8 assertion failed");

// antecedent implies consequent in the same cycle
`define UTF8_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 assertion failed");

`endif

@@ design/utf8_pkg.sv @@
// shared types, constants and decode helpers for the utf8 decoder
package utf8_pkg;

    localparam int OFF_W    = 13;
    localparam int SCALAR_W = 21;
    localparam int LEN_W    = 3;

    localparam int DEF_MAX_BYTES   = 4096;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [SCALAR_W-1:0] MAX_SCALAR = 21'h10ffff;
    localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h00d800;
    localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h00dfff;
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] PAYLOAD6  = 8'h3f;

    typedef enum logic [2:0] {
        ST_SCALAR   = 3'd0,
        ST_END      = 3'd1,
        ST_BAD_LEAD = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_BAD_CONT = 3'd4,
        ST_INVALID  = 3'd5,
        ST_TOO_LONG = 3'd6
    } status_t;

    // one output record
    typedef struct packed {
        logic [SCALAR_W-1:0] scalar;
        logic [OFF_W-1:0]    offset;
        logic [LEN_W-1:0]    len;
        status_t             status;
        logic                fin;
    } rec_t;

    // one queue word: a record, optionally followed by an end record
    typedef struct packed {
        rec_t             rec;
        logic             has_end;
        logic [OFF_W-1:0] end_offset;
    } entry_t;

    // encoded length from the lead byte, 0 for an illegal lead
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        len = 3'd0;
        if (b < 8'h80)
            len = 3'd1;
        else if (b >= 8'hc2 && b <= 8'hdf)
            len = 3'd2;
        else if (b >= 8'he0 && b <= 8'hef)
            len = 3'd3;
        else if (b >= 8'hf0 && b <= 8'hf4)
            len = 3'd4;
        return len;
    endfunction

    // overlong, surrogate or out of range
    function automatic logic scalar_invalid(input logic [SCALAR_W-1:0] code,
                                            input logic [LEN_W-1:0] len);
        logic bad;
        bad = 1'b0;
        if (len == 3'd2 && code < 21'h80)
            bad = 1'b1;
        if (len == 3'd3 && code < 21'h800)
            bad = 1'b1;
        if (len == 3'd4 && code < 21'h10000)
            bad = 1'b1;
        if (code > MAX_SCALAR)
            bad = 1'b1;
        if (code >= SURR_LO && code <= SURR_HI)
            bad = 1'b1;
        return bad;
    endfunction

endpackage

@@ design/utf8_scalar_decoder_validator.sv @@
// utf8 decoder and validator top level: decode front end, queue, output stage
// an accepted byte's records pass through the queue into the output register
// throughput: one byte per cycle while the queue is not full; a byte that yields a scalar and
//   an end record holds the output stage for both records, so a run of them can fill the queue
// reset: asynchronous active low; clears decode state, empties the queue and
//   drops any record held at the output
module utf8_scalar_decoder_validator #(
    parameter int MAX_BYTES   = utf8_pkg::DEF_MAX_BYTES,
    parameter int QUEUE_DEPTH = utf8_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] scalar_value,
    output logic [12:0] byte_offset,
    output logic [2:0]  sequence_bytes,
    output logic [2:0]  status,
    output logic        final_record
);
    import utf8_pkg::*;

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    logic   q_valid;
    entry_t q_entry;
    rec_t   out_rec;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // decode front end
    utf8_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .push          (push),
        .push_entry    (push_entry)
    );

    // word queue
    utf8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // output stage
    utf8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rec   (out_rec)
    );

    assign scalar_value   = out_rec.scalar;
    assign byte_offset    = out_rec.offset;
    assign sequence_bytes = out_rec.len;
    assign status         = 3'(out_rec.status);
    assign final_record   = out_rec.fin;

endmodule

@@ design/utf8_front.sv @@
// front end: takes bytes, runs the utf8 decode state and builds queue words
module utf8_front #(
    parameter int MAX_BYTES = utf8_pkg::DEF_MAX_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            end_of_string,
    output logic            push,
    output utf8_pkg::entry_t push_entry
);
    import utf8_pkg::*;

    localparam int RAW_CNT_W = $clog2(MAX_BYTES + 1);
    localparam int CNT_W     = (RAW_CNT_W > OFF_W) ? RAW_CNT_W : OFF_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

    logic [SCALAR_W-1:0] partial_reg, partial_next;
    logic [1:0]          remain_reg, remain_next;
    logic [LEN_W-1:0]    seqlen_reg, seqlen_next;
    logic [OFF_W-1:0]    seqstart_reg, seqstart_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                pend_reg, pend_next;
    logic                failed_reg, failed_next;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            remain_reg   <= '0;
            seqlen_reg   <= '0;
            seqstart_reg <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            partial_reg  <= partial_next;
            remain_reg   <= remain_next;
            seqlen_reg   <= seqlen_next;
            seqstart_reg <= seqstart_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            failed_reg   <= failed_next;
        end
    end

    // per-byte decode
    always_comb
    begin
        logic                done;
        logic [LEN_W-1:0]    llen;
        logic                cont_bad;
        logic [SCALAR_W-1:0] shifted;
        logic [1:0]          rem_dec;
        logic                pend_upd;
        logic [CNT_W-1:0]    cnt_inc;
        logic [OFF_W-1:0]    pos;

        partial_next  = partial_reg;
        remain_next   = remain_reg;
        seqlen_next   = seqlen_reg;
        seqstart_next = seqstart_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        failed_next   = failed_reg;
        push          = 1'b0;
        push_entry    = '0;
        done          = 1'b0;

        llen     = lead_length(data_byte);
        cont_bad = (data_byte & CONT_MASK) != CONT_TAG;
        shifted  = {partial_reg[SCALAR_W-7:0], data_byte[5:0]};
        rem_dec  = remain_reg - 2'd1;
        pend_upd = pend_reg | cont_bad;
        cnt_inc  = count_reg + CNT_W'(1);
        pos      = count_reg[OFF_W-1:0];

        if (accept)
        begin
            if (failed_reg)
            begin
                // bytes after an error are dropped until the final byte
                done = 1'b1;
            end
            else if (count_reg >= MAX_CNT)
            begin
                push              = 1'b1;
                push_entry.rec.offset = MAX_CNT[OFF_W-1:0];
                push_entry.rec.status = ST_TOO_LONG;
                push_entry.rec.fin    = 1'b1;
                failed_next       = 1'b1;
                done              = 1'b1;
            end
            else
            begin
                count_next = cnt_inc;
                if (remain_reg == 2'd0)
                begin
                    // lead byte
                    if (llen == 3'd0)
                    begin
                        push                  = 1'b1;
                        push_entry.rec.offset = pos;
                        push_entry.rec.status = ST_BAD_LEAD;
                        push_entry.rec.fin    = 1'b1;
                        failed_next           = 1'b1;
                        done                  = 1'b1;
                    end
                    else if (llen == 3'd1)
                    begin
                        push                  = 1'b1;
                        push_entry.rec.scalar = SCALAR_W'(data_byte);
                        push_entry.rec.offset = pos;
                        push_entry.rec.len    = 3'd1;
                        push_entry.rec.status = ST_SCALAR;
                    end
                    else
                    begin
                        unique case (llen)
                            3'd2:    partial_next = SCALAR_W'(data_byte[4:0]);
                            3'd3:    partial_next = SCALAR_W'(data_byte[3:0]);
                            default: partial_next = SCALAR_W'(data_byte[2:0]);
                        endcase
                        remain_next   = 2'(llen - 3'd1);
                        seqlen_next   = llen;
                        seqstart_next = pos;
                        pend_next     = 1'b0;
                        if (end_of_string)
                        begin
                            push                  = 1'b1;
                            push_entry.rec.offset = pos;
                            push_entry.rec.status = ST_TRUNC;
                            push_entry.rec.fin    = 1'b1;
                            done                  = 1'b1;
                        end
                    end
                end
                else
                begin
                    // continuation byte
                    pend_next   = pend_upd;
                    remain_next = rem_dec;
                    if (!cont_bad)
                        partial_next = shifted;
                    if (rem_dec == 2'd0)
                    begin
                        push                  = 1'b1;
                        push_entry.rec.offset = seqstart_reg;
                        if (pend_upd)
                        begin
                            push_entry.rec.status = ST_BAD_CONT;
                            push_entry.rec.fin    = 1'b1;
                            failed_next           = 1'b1;
                            done                  = 1'b1;
                        end
                        else if (scalar_invalid(shifted, seqlen_reg))
                        begin
                            push_entry.rec.status = ST_INVALID;
                            push_entry.rec.fin    = 1'b1;
                            failed_next           = 1'b1;
                            done                  = 1'b1;
                        end
                        else
                        begin
                            push_entry.rec.scalar = shifted;
                            push_entry.rec.len    = seqlen_reg;
                            push_entry.rec.status = ST_SCALAR;
                            partial_next          = '0;
                            seqlen_next           = '0;
                        end
                    end
                    else if (end_of_string)
                    begin
                        push                  = 1'b1;
                        push_entry.rec.offset = seqstart_reg;
                        push_entry.rec.status = ST_TRUNC;
                        push_entry.rec.fin    = 1'b1;
                        done                  = 1'b1;
                    end
                end
            end

            // end record on a clean final byte
            if (end_of_string && !done)
            begin
                push                  = 1'b1;
                push_entry.has_end    = 1'b1;
                push_entry.end_offset = cnt_inc[OFF_W-1:0];
                if (!push_entry.rec.len[0] && !push_entry.rec.len[1]
                    && !push_entry.rec.len[2])
                begin
                    // no scalar this byte: the end record goes out alone
                    push_entry.has_end    = 1'b0;
                    push_entry.rec.offset = cnt_inc[OFF_W-1:0];
                    push_entry.rec.status = ST_END;
                    push_entry.rec.fin    = 1'b1;
                end
            end

            // final byte clears the string state
            if (end_of_string)
            begin
                partial_next  = '0;
                remain_next   = '0;
                seqlen_next   = '0;
                seqstart_next = '0;
                count_next    = '0;
                pend_next     = 1'b0;
                failed_next   = 1'b0;
            end
        end
    end

endmodule

@@ design/utf8_queue.sv @@
// small word queue between the decode front end and the output stage
module utf8_queue #(
    parameter int DEPTH = utf8_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  utf8_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output utf8_pkg::entry_t q_entry
);
    import utf8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == FULL_CNT);
    assign q_valid = (cnt_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ design/utf8_back.sv @@
// output stage: pops queue words and presents their records, one per output handshake
module utf8_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  utf8_pkg::entry_t q_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output utf8_pkg::rec_t   out_rec
);
    import utf8_pkg::*;

`include "utf8_scalar_decoder_validator_assert.svh"

    logic             out_valid_reg, out_valid_next;
    logic             end_pend_reg, end_pend_next;
    rec_t             rec_reg, rec_next;
    logic [OFF_W-1:0] end_off_reg, end_off_next;
    logic             load;

    assign load      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_rec   = rec_reg;

    // pick the next record: a held end record first, then the queue
    always_comb
    begin
        out_valid_next = out_valid_reg;
        end_pend_next  = end_pend_reg;
        rec_next       = rec_reg;
        end_off_next   = end_off_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (end_pend_reg)
            begin
                rec_next        = '0;
                rec_next.offset = end_off_reg;
                rec_next.status = ST_END;
                rec_next.fin    = 1'b1;
                out_valid_next  = 1'b1;
                end_pend_next   = 1'b0;
            end
            else if (q_valid)
            begin
                pop            = 1'b1;
                rec_next       = q_entry.rec;
                end_pend_next  = q_entry.has_end;
                end_off_next   = q_entry.end_offset;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            end_pend_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            end_pend_reg  <= end_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rec_reg     <= rec_next;
        end_off_reg <= end_off_next;
    end

    // checks
    `UTF8_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, pop, q_valid)
    `UTF8_ASSERT_IMPLY(a_end_follows_word, clk, rst_n, end_pend_reg, out_valid_reg)
    `UTF8_ASSERT_IMPLY(a_scalar_shape, clk, rst_n,
        out_valid_reg && rec_reg.status == ST_SCALAR,
        !rec_reg.fin && rec_reg.len != '0)
    `UTF8_ASSERT_IMPLY(a_final_shape, clk, rst_n,
        out_valid_reg && rec_reg.status != ST_SCALAR,
        rec_reg.fin && rec_reg.len == '0 && rec_reg.scalar == '0)

endmodule
